>>> design/dllce_pkg.sv
// ----------------------------------------------------------------------------
// dllce_pkg: shared types and codes for the linked list cursor engine
// Operation codes, pool defaults and the controller-datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package dllce_pkg;
  localparam int NodesDef = 64;

  localparam logic [4:0] OP_CLEAR     = 5'd0;
  localparam logic [4:0] OP_INSFIRST  = 5'd1;
  localparam logic [4:0] OP_INSLAST   = 5'd2;
  localparam logic [4:0] OP_CURFIRST  = 5'd3;
  localparam logic [4:0] OP_CURLAST   = 5'd4;
  localparam logic [4:0] OP_GETFIRST  = 5'd5;
  localparam logic [4:0] OP_GETLAST   = 5'd6;
  localparam logic [4:0] OP_DELFIRST  = 5'd7;
  localparam logic [4:0] OP_DELLAST   = 5'd8;
  localparam logic [4:0] OP_DELAFTER  = 5'd9;
  localparam logic [4:0] OP_DELBEFORE = 5'd10;
  localparam logic [4:0] OP_INSAFTER  = 5'd11;
  localparam logic [4:0] OP_INSBEFORE = 5'd12;
  localparam logic [4:0] OP_GET       = 5'd13;
  localparam logic [4:0] OP_SET       = 5'd14;
  localparam logic [4:0] OP_NEXT      = 5'd15;
  localparam logic [4:0] OP_PREV      = 5'd16;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming beat
    logic rd1;    // read links of the first node
    logic rd2;    // read links of the neighbour
    logic exec;   // apply the operation
  } dllce_cmd_t;
endpackage
`default_nettype wire

>>> design/doubly_linked_list_cursor_engine.sv
// ----------------------------------------------------------------------------
// doubly_linked_list_cursor_engine: list of 64-bit values with one cursor
// Top level: sequencer, node pool datapath and result register.
// ----------------------------------------------------------------------------
// Each beat carries one list operation and returns one result beat. An
// operation passes from acceptance to the result register through load,
// read of the cursor (or head/tail) node links, read of its neighbour,
// write-back of the links and result capture; the two dependent reads of the
// link memories need the two separate read steps. The next beat is taken once
// the result has moved to the output register, so the engine works on one
// operation at a time. The pool holds NODES nodes; no clearing pass is
// needed after reset.
`default_nettype none
module doubly_linked_list_cursor_engine #(
  parameter int NODES = dllce_pkg::NodesDef
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [71:0]  in_tdata,   // func[4:0], value[68:5], zero pad
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [79:0]  out_tdata   // read_value[63:0], error, active, length[72:66]
);
  import dllce_pkg::*;

  dllce_cmd_t  cmd;
  logic        res_load, res_free;
  logic [63:0] rd_val;
  logic        err, act;
  logic [6:0]  len;
  logic        ovalid_r;
  logic [79:0] odata_r;

  assign res_free = !ovalid_r || out_tready;

  dllce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .res_load (res_load),
    .res_free (res_free),
    .cmd      (cmd)
  );

  dllce_dpath #(.NODES(NODES)) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .func       (in_tdata[4:0]),
    .value      (in_tdata[68:5]),
    .read_value (rd_val),
    .error      (err),
    .active     (act),
    .length     (len)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (res_load) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      odata_r <= {7'd0, len, act, err, rd_val};
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
endmodule
`default_nettype wire

>>> design/dllce_ctrl.sv
// ----------------------------------------------------------------------------
// dllce_ctrl: operation sequencer
// Steps each beat through load, two link reads, execute and result.
// ----------------------------------------------------------------------------
`default_nettype none
module dllce_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  output logic                   res_load,
  input  wire                    res_free,
  output dllce_pkg::dllce_cmd_t  cmd
);
  import dllce_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD1  = 3'd1;
  localparam logic [2:0] S_RD2  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    res_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD1;
        end
      end
      S_RD1: begin
        cmd.rd1   = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

>>> design/dllce_dpath.sv
// ----------------------------------------------------------------------------
// dllce_dpath: node pool and list registers
// Value and link memories, head/tail/cursor, free list and counters.
// ----------------------------------------------------------------------------
`default_nettype none
module dllce_dpath #(
  parameter int NODES = dllce_pkg::NodesDef
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  dllce_pkg::dllce_cmd_t  cmd,
  input  wire  [4:0]             func,
  input  wire  [63:0]            value,
  output logic [63:0]            read_value,
  output logic                   error,
  output logic                   active,
  output logic [6:0]             length
);
  import dllce_pkg::*;

  localparam int IW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);
  localparam logic [IW-1:0] NIL = IW'(NODES);

  logic [63:0]   mem_val [NODES];
  logic [IW-1:0] mem_nx  [NODES];
  logic [IW-1:0] mem_pv  [NODES];

  logic [4:0]    func_r;
  logic [63:0]   val_r;
  logic [IW-1:0] head_r, tail_r, cur_r, free_r, fresh_r, cnt_r;
  // first read: cursor or head/tail node
  logic [IW-1:0] a_nx_r, a_pv_r, fh_nx_r;
  logic [63:0]   a_val_r;
  // second read: neighbour of the first node
  logic [IW-1:0] b_nx_r, b_pv_r;

  logic [IW-1:0] aidx, bidx;
  logic          a_ok, b_ok;

  always_comb begin
    aidx = cur_r;
    unique case (func_r)
      OP_GETFIRST, OP_DELFIRST: aidx = head_r;
      OP_GETLAST, OP_DELLAST:   aidx = tail_r;
      default:                  aidx = cur_r;
    endcase
    a_ok = (aidx != NIL);
    // delafter/delbefore need the node beside the cursor
    bidx = (func_r == OP_DELBEFORE) ? a_pv_r : a_nx_r;
    b_ok = (bidx != NIL);
  end

  // read phases
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= func;
      val_r  <= value;
    end
    if (cmd.rd1) begin
      if (a_ok) begin
        a_nx_r  <= mem_nx[aidx[AW-1:0]];
        a_pv_r  <= mem_pv[aidx[AW-1:0]];
        a_val_r <= mem_val[aidx[AW-1:0]];
      end else begin
        a_nx_r  <= NIL;
        a_pv_r  <= NIL;
        a_val_r <= '0;
      end
      fh_nx_r <= (free_r != NIL) ? mem_nx[free_r[AW-1:0]] : NIL;
    end
    if (cmd.rd2) begin
      if (b_ok) begin
        b_nx_r <= mem_nx[bidx[AW-1:0]];
        b_pv_r <= mem_pv[bidx[AW-1:0]];
      end else begin
        b_nx_r <= NIL;
        b_pv_r <= NIL;
      end
    end
  end

  // execute: compute writes and next register values
  logic [IW-1:0] head_nxt, tail_nxt, cur_nxt, free_nxt, fresh_nxt, cnt_nxt;
  logic          err_nxt;
  logic [63:0]   rd_nxt;
  logic          w1_en, w2_en, w3_en, wv_en;
  logic [IW-1:0] w1_i, w2_i, w3_i, wv_i;
  logic          w1_n, w1_p, w2_n, w2_p, w3_n;
  logic [IW-1:0] w1_nv, w1_pv, w2_nv, w2_pv, w3_nv;
  logic [IW-1:0] newn;
  logic          have_new, ins_new;

  always_comb begin
    head_nxt = head_r; tail_nxt = tail_r; cur_nxt = cur_r;
    free_nxt = free_r; fresh_nxt = fresh_r; cnt_nxt = cnt_r;
    err_nxt = 1'b0; rd_nxt = '0;
    w1_en = 1'b0; w2_en = 1'b0; w3_en = 1'b0; wv_en = 1'b0;
    w1_i = NIL; w2_i = NIL; w3_i = NIL; wv_i = NIL;
    w1_n = 1'b0; w1_p = 1'b0; w2_n = 1'b0; w2_p = 1'b0; w3_n = 1'b0;
    w1_nv = NIL; w1_pv = NIL; w2_nv = NIL; w2_pv = NIL; w3_nv = NIL;
    have_new = (free_r != NIL) || (fresh_r < IW'(NODES));
    newn     = (free_r != NIL) ? free_r : fresh_r;
    ins_new  = 1'b0;
    unique case (func_r)
      OP_CLEAR: begin
        if (head_r != NIL) begin
          w1_en = 1'b1; w1_i = tail_r; w1_n = 1'b1; w1_nv = free_r;
          free_nxt = head_r;
        end
        head_nxt = NIL; tail_nxt = NIL; cur_nxt = NIL; cnt_nxt = '0;
      end
      OP_INSFIRST, OP_INSLAST: begin
        if (!have_new) begin
          err_nxt = 1'b1;
        end else begin
          ins_new = 1'b1;
          wv_en = 1'b1; wv_i = newn;
          w1_en = 1'b1; w1_i = newn; w1_n = 1'b1; w1_p = 1'b1;
          if (func_r == OP_INSFIRST) begin
            w1_pv = NIL; w1_nv = head_r;
            if (head_r == NIL) tail_nxt = newn;
            else begin w2_en = 1'b1; w2_i = head_r; w2_p = 1'b1; w2_pv = newn; end
            head_nxt = newn;
          end else begin
            w1_nv = NIL; w1_pv = tail_r;
            if (tail_r == NIL) head_nxt = newn;
            else begin w2_en = 1'b1; w2_i = tail_r; w2_n = 1'b1; w2_nv = newn; end
            tail_nxt = newn;
          end
        end
      end
      OP_CURFIRST: cur_nxt = head_r;
      OP_CURLAST:  cur_nxt = tail_r;
      OP_GETFIRST, OP_GETLAST: begin
        if (!a_ok) err_nxt = 1'b1;
        else begin rd_nxt = a_val_r; cur_nxt = aidx; end
      end
      OP_DELFIRST, OP_DELLAST: begin
        if (a_ok) begin
          if (cur_r == aidx) cur_nxt = NIL;
          if (head_r == tail_r) begin
            head_nxt = NIL; tail_nxt = NIL;
          end else if (func_r == OP_DELFIRST) begin
            head_nxt = a_nx_r;
            w2_en = 1'b1; w2_i = a_nx_r; w2_p = 1'b1; w2_pv = NIL;
          end else begin
            tail_nxt = a_pv_r;
            w2_en = 1'b1; w2_i = a_pv_r; w2_n = 1'b1; w2_nv = NIL;
          end
          w1_en = 1'b1; w1_i = aidx; w1_n = 1'b1; w1_nv = free_r;
          free_nxt = aidx; cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_DELAFTER: begin
        if (a_ok && b_ok) begin
          w2_en = 1'b1; w2_i = aidx; w2_n = 1'b1; w2_nv = b_nx_r;
          if (bidx == tail_r) tail_nxt = aidx;
          else begin w3_en = 1'b1; w3_i = b_nx_r; end
          w1_en = 1'b1; w1_i = bidx; w1_n = 1'b1; w1_nv = free_r;
          free_nxt = bidx; cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_DELBEFORE: begin
        if (a_ok && b_ok) begin
          w2_en = 1'b1; w2_i = aidx; w2_p = 1'b1; w2_pv = b_pv_r;
          if (bidx == head_r) head_nxt = aidx;
          else begin w3_en = 1'b1; w3_i = b_pv_r; w3_n = 1'b1; w3_nv = aidx; end
          w1_en = 1'b1; w1_i = bidx; w1_n = 1'b1; w1_nv = free_r;
          free_nxt = bidx; cnt_nxt = cnt_r - 1'b1;
        end
      end
      OP_INSAFTER, OP_INSBEFORE: begin
        if (a_ok) begin
          if (!have_new) err_nxt = 1'b1;
          else begin
            ins_new = 1'b1;
            wv_en = 1'b1; wv_i = newn;
            w1_en = 1'b1; w1_i = newn; w1_n = 1'b1; w1_p = 1'b1;
            w2_en = 1'b1; w2_i = aidx;
            if (func_r == OP_INSAFTER) begin
              w1_nv = a_nx_r; w1_pv = aidx;
              w2_n = 1'b1; w2_nv = newn;
              if (aidx == tail_r) tail_nxt = newn;
              else begin w3_en = 1'b1; w3_i = a_nx_r; end
            end else begin
              w1_pv = a_pv_r; w1_nv = aidx;
              w2_p = 1'b1; w2_pv = newn;
              if (aidx == head_r) head_nxt = newn;
              else begin w3_en = 1'b1; w3_i = a_pv_r; w3_n = 1'b1; w3_nv = newn; end
            end
          end
        end
      end
      OP_GET: begin
        if (!a_ok) err_nxt = 1'b1;
        else rd_nxt = a_val_r;
      end
      OP_SET: begin
        if (a_ok) begin wv_en = 1'b1; wv_i = aidx; end
      end
      OP_NEXT: if (a_ok) cur_nxt = a_nx_r;
      OP_PREV: if (a_ok) cur_nxt = a_pv_r;
      default: ;
    endcase
    if (ins_new) begin
      cnt_nxt = cnt_r + 1'b1;
      if (free_r != NIL) free_nxt = fh_nx_r;
      else fresh_nxt = fresh_r + 1'b1;
    end
  end

  // third write serves prev for after-insert/delete and next otherwise
  logic [IW-1:0] w3_pv;
  always_comb begin
    w3_pv = NIL;
    unique case (func_r)
      OP_DELAFTER: w3_pv = aidx;
      OP_INSAFTER: w3_pv = newn;
      default:     w3_pv = NIL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (wv_en && wv_i != NIL) mem_val[wv_i[AW-1:0]] <= val_r;
      if (w1_en && w1_i != NIL) begin
        if (w1_n) mem_nx[w1_i[AW-1:0]] <= w1_nv;
        if (w1_p) mem_pv[w1_i[AW-1:0]] <= w1_pv;
      end
      if (w2_en && w2_i != NIL) begin
        if (w2_n) mem_nx[w2_i[AW-1:0]] <= w2_nv;
        if (w2_p) mem_pv[w2_i[AW-1:0]] <= w2_pv;
      end
      if (w3_en && w3_i != NIL) begin
        if (w3_n) mem_nx[w3_i[AW-1:0]] <= w3_nv;
        else      mem_pv[w3_i[AW-1:0]] <= w3_pv;
      end
      read_value <= rd_nxt;
      error      <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= NIL; tail_r <= NIL; cur_r <= NIL; free_r <= NIL;
      fresh_r <= '0; cnt_r <= '0;
    end else if (cmd.exec) begin
      head_r <= head_nxt; tail_r <= tail_nxt; cur_r <= cur_nxt;
      free_r <= free_nxt; fresh_r <= fresh_nxt; cnt_r <= cnt_nxt;
    end
  end

  assign active = (cur_r != NIL);
  always_comb begin
    length = '0;
    for (int i = 0; i < 7; i++) begin
      if (i < IW) length[i] = cnt_r[i];
    end
  end
endmodule
`default_nettype wire

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the doubly linked list cursor engine
// Drives list operations over the input stream, predicts each result with a
// behavioural list model and checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import dllce_pkg::*;

  localparam int NODES = NodesDef;
  localparam int NIL = NODES;
  localparam int STALL_LIMIT = 5000;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [71:0] in_tdata;   // func[4:0], value[68:5], zero pad
  logic out_tvalid;
  logic out_tready;
  logic [79:0] out_tdata;  // read_value[63:0], error, active, length[72:66]

  // first member sits in the highest bits
  typedef struct packed {
    logic [6:0] length;
    logic active;
    logic error;
    logic [63:0] read_value;
  } list_result_t;

  // behavioural list state
  logic [63:0] pool_val[NODES];
  int pool_nxt[NODES];
  int pool_prv[NODES];
  int head_n, tail_n, cur_n, free_n, fresh_n, count_n;

  list_result_t pending_results[$];
  int fails;
  int idle_cycles;
  int burst_left;

  doubly_linked_list_cursor_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int alloc_node();
    int n;
    if (free_n != NIL) begin
      n = free_n;
      free_n = pool_nxt[n];
      return n;
    end
    if (fresh_n < NODES) begin
      n = fresh_n;
      fresh_n++;
      return n;
    end
    return NIL;
  endfunction

  function automatic void release_node(int n);
    pool_nxt[n] = free_n;
    free_n = n;
    if (count_n > 0) count_n--;
  endfunction

  function automatic list_result_t apply_list_op(logic [4:0] op, logic [63:0] v);
    list_result_t r;
    int c, n, d;
    r = '0;
    c = cur_n;
    case (op)
      OP_CLEAR: begin
        if (head_n != NIL) begin
          pool_nxt[tail_n] = free_n;
          free_n = head_n;
        end
        head_n = NIL; tail_n = NIL; cur_n = NIL; count_n = 0;
      end
      OP_INSFIRST, OP_INSLAST: begin
        n = alloc_node();
        if (n == NIL) r.error = 1'b1;
        else begin
          pool_val[n] = v;
          if (op == OP_INSFIRST) begin
            pool_prv[n] = NIL; pool_nxt[n] = head_n;
            if (head_n == NIL) tail_n = n; else pool_prv[head_n] = n;
            head_n = n;
          end else begin
            pool_nxt[n] = NIL; pool_prv[n] = tail_n;
            if (tail_n == NIL) head_n = n; else pool_nxt[tail_n] = n;
            tail_n = n;
          end
          count_n++;
        end
      end
      OP_CURFIRST: cur_n = head_n;
      OP_CURLAST: cur_n = tail_n;
      OP_GETFIRST, OP_GETLAST: begin
        n = (op == OP_GETFIRST) ? head_n : tail_n;
        if (n == NIL) r.error = 1'b1;
        else begin
          r.read_value = pool_val[n];
          cur_n = n;
        end
      end
      OP_DELFIRST: begin
        d = head_n;
        if (d != NIL) begin
          if (c == d) cur_n = NIL;
          if (d == tail_n) begin
            head_n = NIL; tail_n = NIL;
          end else begin
            head_n = pool_nxt[d]; pool_prv[head_n] = NIL;
          end
          release_node(d);
        end
      end
      OP_DELLAST: begin
        d = tail_n;
        if (d != NIL) begin
          if (c == d) cur_n = NIL;
          if (d == head_n) begin
            head_n = NIL; tail_n = NIL;
          end else begin
            tail_n = pool_prv[d]; pool_nxt[tail_n] = NIL;
          end
          release_node(d);
        end
      end
      OP_DELAFTER: begin
        if (c != NIL && pool_nxt[c] != NIL) begin
          d = pool_nxt[c];
          pool_nxt[c] = pool_nxt[d];
          if (d == tail_n) tail_n = c; else pool_prv[pool_nxt[d]] = c;
          release_node(d);
        end
      end
      OP_DELBEFORE: begin
        if (c != NIL && pool_prv[c] != NIL) begin
          d = pool_prv[c];
          pool_prv[c] = pool_prv[d];
          if (d == head_n) head_n = c; else pool_nxt[pool_prv[d]] = c;
          release_node(d);
        end
      end
      OP_INSAFTER, OP_INSBEFORE: begin
        if (c != NIL) begin
          n = alloc_node();
          if (n == NIL) r.error = 1'b1;
          else begin
            pool_val[n] = v;
            if (op == OP_INSAFTER) begin
              pool_nxt[n] = pool_nxt[c]; pool_prv[n] = c;
              if (c == tail_n) tail_n = n; else pool_prv[pool_nxt[c]] = n;
              pool_nxt[c] = n;
            end else begin
              pool_prv[n] = pool_prv[c]; pool_nxt[n] = c;
              if (c == head_n) head_n = n; else pool_nxt[pool_prv[c]] = n;
              pool_prv[c] = n;
            end
            count_n++;
          end
        end
      end
      OP_GET: begin
        if (c == NIL) r.error = 1'b1;
        else r.read_value = pool_val[c];
      end
      OP_SET: if (c != NIL) pool_val[c] = v;
      OP_NEXT: if (c != NIL) cur_n = pool_nxt[c];
      OP_PREV: if (c != NIL) cur_n = pool_prv[c];
      default: ;
    endcase
    r.active = (cur_n != NIL);
    r.length = count_n[6:0];
    return r;
  endfunction

  // sender: bursts of random length with random gaps between them
  task automatic send_op(logic [4:0] op, logic [63:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {3'b0, v, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_list_op(op, v));
  endtask

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 64'h8000_0000_0000_0000;
      1: return 64'h7fff_ffff_ffff_ffff;
      2: return '1;
      3: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic test_directed();
    send_op(OP_GET, '0);
    send_op(OP_GETFIRST, '0);
    send_op(OP_GETLAST, '0);
    send_op(OP_DELFIRST, '0);
    send_op(OP_DELLAST, '0);
    send_op(OP_INSAFTER, 64'h1);
    send_op(OP_NEXT, '0);
    send_op(OP_INSFIRST, 64'h8000_0000_0000_0000);
    send_op(OP_INSLAST, 64'h7fff_ffff_ffff_ffff);
    send_op(OP_CURFIRST, '0);
    send_op(OP_INSAFTER, '1);
    send_op(OP_INSBEFORE, 64'h5555_aaaa_5555_aaaa);
    send_op(OP_GET, '0);
    send_op(OP_SET, 64'haaaa_5555_aaaa_5555);
    send_op(OP_PREV, '0);
    send_op(OP_PREV, '0);
    send_op(OP_CURLAST, '0);
    send_op(OP_DELBEFORE, '0);
    send_op(OP_DELAFTER, '0);
    send_op(OP_GETFIRST, '0);
    send_op(OP_DELFIRST, '0);
    send_op(5'd31, '1);
    send_op(5'd17, '0);
    send_op(OP_GETLAST, '0);
    send_op(OP_CLEAR, '0);
  endtask

  // fill the pool past full, exercise inserts and a delete around the cursor, then clear and refill from the front
  task automatic test_full_pool();
    for (int i = 0; i < NODES + 2; i++) send_op(OP_INSLAST, rand_value());
    send_op(OP_CURFIRST, '0);
    send_op(OP_INSAFTER, '0);
    send_op(OP_INSBEFORE, '0);
    send_op(OP_NEXT, '0);
    send_op(OP_DELBEFORE, '0);
    send_op(OP_INSBEFORE, 64'h1234);
    send_op(OP_CLEAR, '0);
    send_op(OP_INSAFTER, '0);
    for (int i = 0; i < NODES + 1; i++) send_op(OP_INSFIRST, rand_value());
    send_op(OP_CLEAR, '0);
  endtask

  task automatic test_random_ops(int n_items);
    logic [4:0] op;
    for (int i = 0; i < n_items; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: op = OP_INSLAST;
        3, 4: op = OP_INSFIRST;
        5, 6: op = OP_INSAFTER;
        7: op = OP_INSBEFORE;
        8: op = OP_NEXT;
        9: op = OP_PREV;
        10: op = OP_GET;
        11: op = OP_SET;
        12: op = ($urandom_range(0, 1)) ? OP_CURFIRST : OP_CURLAST;
        13: op = ($urandom_range(0, 1)) ? OP_GETFIRST : OP_GETLAST;
        14: op = ($urandom_range(0, 1)) ? OP_DELFIRST : OP_DELLAST;
        15, 16: op = ($urandom_range(0, 1)) ? OP_DELAFTER : OP_DELBEFORE;
        17: op = ($urandom_range(0, 40) == 0) ? OP_CLEAR : OP_GET;
        18: op = ($urandom_range(0, 8) == 0) ? 5'($urandom_range(17, 31)) : OP_NEXT;
        default: op = 5'($urandom_range(0, 16));
      endcase
      send_op(op, rand_value());
    end
  endtask

  // receiver: stalls on a pattern of its own, with stretches of steady readiness
  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(10, 40)) begin
          out_tready <= 1'b1;
          @(posedge clk);
        end
      end else begin
        out_tready <= ($urandom_range(0, 2) != 0);
        @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    list_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[72:0];
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got.read_value !== want.read_value) begin
          $error("read_value expected %h got %h", want.read_value, got.read_value);
          fails++;
        end
        if (got.error !== want.error) begin
          $error("error expected %b got %b", want.error, got.error);
          fails++;
        end
        if (got.active !== want.active) begin
          $error("active expected %b got %b", want.active, got.active);
          fails++;
        end
        if (got.length !== want.length) begin
          $error("length expected %0d got %0d", want.length, got.length);
          fails++;
        end
      end
    end
  end

  // watchdog on beats accepted on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    fails = 0;
    idle_cycles = 0;
    burst_left = 0;
    head_n = NIL; tail_n = NIL; cur_n = NIL; free_n = NIL;
    fresh_n = 0; count_n = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_pool();
    test_random_ops(1500);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

>>> filelist.f
design/dllce_pkg.sv
design/dllce_ctrl.sv
design/dllce_dpath.sv
design/doubly_linked_list_cursor_engine.sv
bench/tb_top.sv
